[rtl/assert_macros.svh]
// Assertion helpers, clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define OWSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define OWSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/owsr_pkg.sv]
package owsr_pkg;

    localparam int OWSR_DEPTH = 64;

    localparam int SAMPLE_W = 16;
    localparam int WLEN_W   = 7;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 2;
    localparam int M_DATA_W = 24;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LONG = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_valid;
        logic                       last;
        logic [STAT_W-1:0]          status;
        logic                       is_empty;
        logic                       is_full;
    } out_item_t;

endpackage

[rtl/owsr_ram.sv]
module owsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/overlap_window_sample_ring.sv]
// Sample ring with overlapping window reads.
// Input channel s_*: tuser carries the operation (write, window read, clear),
// tdata the signed sample for a write. Output channel m_*: one item per
// write, clear, refused or zero-length read or other code; window_len items per
// non-empty window read, tlast on the final item of each input item. Every
// output item reports the empty and full state after its operation.
// Writes and clears: one input item per cycle while the output queue has
// room, each result registered into the queue on acceptance. Window read:
// one sample per cycle while the queue has room, set by the single read port of
// the sample memory; the next input item is taken once the last sample has left
// the memory. window_len is written through cfg_wr_en/cfg_wr_data while the
// block idles; the user must keep to this, the block does not enforce it.
// Reset (aresetn low, synchronous) clears positions, the full flag, the output
// queue and the per-entry valid bits, so unwritten entries read as zero;
// window_len returns to 64. A stalled receiver fills the two-entry output
// queue, after which memory reads and input acceptance pause without loss.
module overlap_window_sample_ring
    import owsr_pkg::*;
#(
    parameter int DEPTH = OWSR_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [WLEN_W-1:0]   cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
    input  logic [FUNC_W-1:0]   s_tuser,   // [1:0] func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [15:0] sample_out, [17:16] status,
                                           // [18] is_empty, [19] is_full
    output logic                m_tuser,   // [0] sample_valid
    output logic                m_tlast
);

`include "assert_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [WLEN_W-1:0] DEPTH_LEN = WLEN_W'(DEPTH);
    localparam logic [PTR_W-1:0]  LAST_POS  = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]    DEPTH_EXT = (PTR_W + 1)'(DEPTH);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == LAST_POS) ? '0 : p + PTR_W'(1);
    endfunction

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [PTR_W-1:0]  rd_pos_reg, rd_pos_next;
    logic              full_reg, full_next;
    logic [WLEN_W-1:0] wlen_reg;
    logic [PTR_W-1:0]  addr_reg;
    logic [WLEN_W-1:0] cnt_reg;
    logic              inflight_reg;
    logic              inflight_last_reg;
    logic              vld_rd_reg;
    logic [DEPTH-1:0]  vld_reg;
    out_item_t         q_reg [2];
    logic              q_head_reg, q_tail_reg;
    logic [1:0]        occ_reg;

    logic              accept, pop, push, push_acc, issue, credit_ok;
    logic              start_read, ram_we;
    logic [STAT_W-1:0] acc_status;
    logic [PTR_W:0]    adv_sum;
    logic [PTR_W-1:0]  rd_adv;
    logic [SAMPLE_W-1:0] ram_rdata;
    out_item_t         acc_item, rd_item, push_item, head_item;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE) && !inflight_reg && (occ_reg != 2'd2);
    assign m_tvalid  = (occ_reg != 2'd0);
    assign pop       = m_tvalid && m_tready;
    assign credit_ok = ({1'b0, occ_reg} + 3'(inflight_reg)) <= (3'd1 + 3'(pop));

    assign adv_sum = {1'b0, rd_pos_reg} + (PTR_W + 1)'(wlen_reg >> 1);
    assign rd_adv  = (adv_sum >= DEPTH_EXT) ? PTR_W'(adv_sum - DEPTH_EXT)
                                            : PTR_W'(adv_sum);

    always_comb begin
        wr_pos_next = wr_pos_reg;
        rd_pos_next = rd_pos_reg;
        full_next   = full_reg;
        ram_we      = 1'b0;
        start_read  = 1'b0;
        acc_status  = STAT_OK;
        if (accept) begin
            unique case (s_tuser)
                FUNC_WRITE: begin
                    if (full_reg) begin
                        acc_status = STAT_FULL;
                    end else begin
                        ram_we      = 1'b1;
                        wr_pos_next = ring_next(wr_pos_reg);
                        full_next   = (ring_next(wr_pos_reg) == rd_pos_reg);
                    end
                end
                FUNC_READ: begin
                    if (wlen_reg > DEPTH_LEN) begin
                        acc_status = STAT_LONG;
                    end else begin
                        full_next   = 1'b0;
                        rd_pos_next = rd_adv;
                        start_read  = (wlen_reg != '0);
                    end
                end
                FUNC_CLEAR: begin
                    wr_pos_next = '0;
                    rd_pos_next = '0;
                    full_next   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign push_acc = accept && !start_read;

    always_comb begin
        acc_item              = '0;
        acc_item.last         = 1'b1;
        acc_item.status       = acc_status;
        acc_item.is_empty     = !full_next && (rd_pos_next == wr_pos_next);
        acc_item.is_full      = full_next;

        rd_item               = '0;
        rd_item.sample        = vld_rd_reg ? $signed(ram_rdata) : '0;
        rd_item.sample_valid  = 1'b1;
        rd_item.last          = inflight_last_reg;
        rd_item.status        = STAT_OK;
        rd_item.is_empty      = !full_reg && (rd_pos_reg == wr_pos_reg);
        rd_item.is_full       = full_reg;
    end

    assign push      = push_acc || inflight_reg;
    assign push_item = inflight_reg ? rd_item : acc_item;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start_read) state_next = ST_READ;
            ST_READ: if (issue && cnt_reg == WLEN_W'(1)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        issue = 1'b0;
        unique case (state_reg)
            ST_IDLE: issue = 1'b0;
            ST_READ: issue = credit_ok;
            default: issue = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_pos_reg   <= '0;
            rd_pos_reg   <= '0;
            full_reg     <= 1'b0;
            wlen_reg     <= WLEN_RESET;
            inflight_reg <= 1'b0;
            vld_reg      <= '0;
            q_head_reg   <= 1'b0;
            q_tail_reg   <= 1'b0;
            occ_reg      <= 2'd0;
        end else begin
            state_reg    <= state_next;
            wr_pos_reg   <= wr_pos_next;
            rd_pos_reg   <= rd_pos_next;
            full_reg     <= full_next;
            inflight_reg <= issue;
            if (cfg_wr_en) begin
                wlen_reg <= cfg_wr_data;
            end
            if (ram_we) begin
                vld_reg[wr_pos_reg] <= 1'b1;
            end
            if (push) begin
                q_tail_reg <= ~q_tail_reg;
            end
            if (pop) begin
                q_head_reg <= ~q_head_reg;
            end
            occ_reg <= occ_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (start_read) begin
            addr_reg <= rd_pos_reg;
            cnt_reg  <= wlen_reg;
        end else if (issue) begin
            addr_reg <= ring_next(addr_reg);
            cnt_reg  <= cnt_reg - WLEN_W'(1);
        end
        if (issue) begin
            inflight_last_reg <= (cnt_reg == WLEN_W'(1));
            vld_rd_reg        <= vld_reg[addr_reg];
        end
        if (push) begin
            q_reg[q_tail_reg] <= push_item;
        end
    end

    owsr_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wr_pos_reg),
        .wdata(s_tdata),
        .re   (issue),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    assign head_item = q_reg[q_head_reg];
    assign m_tdata   = {4'b0, head_item.is_full, head_item.is_empty,
                        head_item.status, head_item.sample};
    assign m_tuser   = head_item.sample_valid;
    assign m_tlast   = head_item.last;

    `OWSR_ASSERT(a_full_pos_match, full_reg |-> (rd_pos_reg == wr_pos_reg),
        "full flag set with differing positions")
    `OWSR_ASSERT(a_read_return_room, inflight_reg |-> (occ_reg != 2'd2 || pop),
        "read data returned into a full output queue")
    `OWSR_ASSERT(a_queue_no_overflow, (push && !pop) |-> (occ_reg != 2'd2),
        "output queue overflow")
    `OWSR_ASSERT_NEXT(a_window_end, issue && cnt_reg == WLEN_W'(1),
        state_reg == ST_IDLE && inflight_reg && inflight_last_reg,
        "window read did not end after its last memory read")
    `OWSR_ASSERT_NEXT(a_pos_hold_in_read, state_reg == ST_READ,
        $stable(wr_pos_reg) && $stable(rd_pos_reg),
        "positions moved during a window read")

endmodule

[test/tb_overlap_window_sample_ring.sv]
`timescale 1ns / 1ps

module tb_overlap_window_sample_ring;
    import owsr_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic [FUNC_W-1:0]   func;
        logic [SAMPLE_W-1:0] sample;
    } ring_op_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [WLEN_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // ring model state
    logic [SAMPLE_W-1:0] ring_mem [OWSR_DEPTH] = '{default: '0};
    int unsigned         wr_ptr = 0;
    int unsigned         rd_ptr = 0;
    bit                  ring_full = 1'b0;
    logic [WLEN_W-1:0]   win_len = WLEN_RESET;

    ring_op_t  op_q[$];
    out_item_t results_due[$];
    out_item_t due;
    ring_op_t  tx_next;
    int        ops_queued = 0;
    int        mismatches = 0;
    int        tx_gap = 0;
    int        rx_wait = 0;
    int        rx_draw = 0;
    int        hold_left = 0;
    int        idle_cycles = 0;
    bit        tx_calm = 1'b0;
    bit        rx_calm = 1'b0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;

    overlap_window_sample_ring uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void queue_result(logic [SAMPLE_W-1:0] smp, logic vld, logic lst,
                                         logic [STAT_W-1:0] st);
        out_item_t r;
        r.sample       = smp;
        r.sample_valid = vld;
        r.last         = lst;
        r.status       = st;
        r.is_empty     = !ring_full && (rd_ptr == wr_ptr);
        r.is_full      = ring_full;
        results_due.push_back(r);
    endfunction

    task automatic ring_predict(input logic [FUNC_W-1:0] func,
                                input logic [SAMPLE_W-1:0] smp);
        int unsigned p;
        int unsigned len;
        len = win_len;
        case (func)
            FUNC_WRITE: begin
                if (ring_full) begin
                    queue_result('0, 1'b0, 1'b1, STAT_FULL);
                end else begin
                    ring_mem[wr_ptr] = smp;
                    wr_ptr = (wr_ptr + 1) % OWSR_DEPTH;
                    if (wr_ptr == rd_ptr)
                        ring_full = 1'b1;
                    queue_result('0, 1'b0, 1'b1, STAT_OK);
                end
            end
            FUNC_READ: begin
                if (len > OWSR_DEPTH) begin
                    queue_result('0, 1'b0, 1'b1, STAT_LONG);
                end else begin
                    // state moves first; every sample reports it
                    p = rd_ptr;
                    rd_ptr = (rd_ptr + len / 2) % OWSR_DEPTH;
                    ring_full = 1'b0;
                    if (len == 0)
                        queue_result('0, 1'b0, 1'b1, STAT_OK);
                    for (int i = 0; i < len; i++) begin
                        queue_result(ring_mem[p], 1'b1, (i == len - 1), STAT_OK);
                        p = (p + 1) % OWSR_DEPTH;
                    end
                end
            end
            FUNC_CLEAR: begin
                wr_ptr = 0;
                rd_ptr = 0;
                ring_full = 1'b0;
                queue_result('0, 1'b0, 1'b1, STAT_OK);
            end
            default: begin
                queue_result('0, 1'b0, 1'b1, STAT_OK);
            end
        endcase
    endtask

    function automatic void cmp_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                ring_predict(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    s_tvalid <= 1'b0;
                    tx_gap <= tx_gap - 1;
                end else if (op_q.size() != 0) begin
                    tx_next = op_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= tx_next.func;
                    s_tdata <= tx_next.sample;
                    if ($urandom_range(0, 31) == 0)
                        tx_calm = !tx_calm;
                    tx_gap <= tx_calm ? 0 : $urandom_range(0, 16);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    $error("item with no expected result: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    due = results_due.pop_front();
                    cmp_field("sample_out", int'(due.sample), int'($signed(m_tdata[15:0])));
                    cmp_field("sample_valid", int'(due.sample_valid), int'(m_tuser));
                    cmp_field("last", int'(due.last), int'(m_tlast));
                    cmp_field("status", int'(due.status), int'(m_tdata[17:16]));
                    cmp_field("is_empty", int'(due.is_empty), int'(m_tdata[18]));
                    cmp_field("is_full", int'(due.is_full), int'(m_tdata[19]));
                end
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                rx_draw = rx_calm ? 0 : $urandom_range(0, 16);
                rx_wait <= rx_draw;
                m_tready <= (rx_draw == 0);
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_tready <= (rx_wait == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_op(input logic [FUNC_W-1:0] func, input logic [SAMPLE_W-1:0] smp);
        ring_op_t op;
        op.func = func;
        op.sample = smp;
        op_q.push_back(op);
        ops_queued++;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 16'h7FFF;
        if (pick == 1)
            return 16'h8000;
        return SAMPLE_W'($urandom());
    endfunction

    function automatic int unsigned pick_window();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 0;
        if (pick < 20)
            return OWSR_DEPTH;
        if (pick < 28)
            return $urandom_range(OWSR_DEPTH + 1, 127);
        if (pick < 35)
            return 1;
        return $urandom_range(2, 12);
    endfunction

    task automatic set_window(input int unsigned len);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len[WLEN_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_len = len[WLEN_W-1:0];
        @(negedge aclk);
    endtask

    task automatic drain();
        do
            @(negedge aclk);
        while (op_q.size() != 0 || s_tvalid || results_due.size() != 0);
        repeat (16) @(negedge aclk);
    endtask

    task automatic random_phase(input int n_ops);
        int start;
        int pick;
        int burst;
        start = ops_queued;
        while (ops_queued - start < n_ops) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // write run
                burst = $urandom_range(4, 70);
                if (burst > n_ops - (ops_queued - start))
                    burst = n_ops - (ops_queued - start);
                repeat (burst) add_op(FUNC_WRITE, rand_sample());
            end else if (pick < 60) begin
                add_op(FUNC_WRITE, rand_sample());
            end else if (pick < 85) begin
                add_op(FUNC_READ, rand_sample());
            end else if (pick < 93) begin
                add_op(FUNC_CLEAR, rand_sample());
            end else begin
                add_op(FUNC_NONE, rand_sample());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset window length, unwritten store reads zero
        add_op(FUNC_READ, 16'h0000);
        add_op(FUNC_WRITE, 16'h7FFF);
        add_op(FUNC_WRITE, 16'h8000);
        add_op(FUNC_WRITE, 16'hFFFF);
        add_op(FUNC_WRITE, 16'h0000);
        add_op(FUNC_WRITE, 16'h5555);
        add_op(FUNC_WRITE, 16'hAAAA);
        add_op(FUNC_NONE, 16'h1234);
        add_op(FUNC_CLEAR, 16'hFFFF);
        add_op(FUNC_READ, 16'h0000);
        drain();

        // read moves rd to 1, one write then fills, next is refused
        set_window(2);
        add_op(FUNC_CLEAR, 16'h0000);
        add_op(FUNC_READ, 16'h0000);
        add_op(FUNC_WRITE, 16'h4321);
        add_op(FUNC_WRITE, 16'h1111);
        add_op(FUNC_NONE, 16'h0000);
        add_op(FUNC_READ, 16'h0000);
        add_op(FUNC_CLEAR, 16'h0000);
        drain();

        set_window(0);
        add_op(FUNC_WRITE, 16'h00FF);
        add_op(FUNC_READ, 16'h0000);
        add_op(FUNC_CLEAR, 16'h0000);
        drain();

        set_window(1);
        add_op(FUNC_WRITE, 16'hFF00);
        add_op(FUNC_READ, 16'h0000);
        add_op(FUNC_READ, 16'h0000);
        drain();

        set_window(OWSR_DEPTH + 1);
        add_op(FUNC_READ, 16'h0000);
        add_op(FUNC_WRITE, 16'h0F0F);
        drain();

        set_window(127);
        add_op(FUNC_READ, 16'h0000);
        drain();

        set_window(OWSR_DEPTH);
        add_op(FUNC_READ, 16'h0000);
        drain();

        // receiver holds off while the sender keeps offering
        set_window(4);
        random_phase(30);
        hold_req = 1'b1;
        drain();

        repeat (6) begin
            set_window(pick_window());
            random_phase(20);
            drain();
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
